// ===== hdl/ncs_pkg.sv =====
// Shared types, codes and constants for the nested comment scanner.
package ncs_pkg;

  localparam int CP_W     = 21;
  localparam int NEST_W   = 8;
  localparam int MAX_NEST = 255;

  // Depth saturates at the smaller of MAX_NEST and what the depth register holds.
  localparam int NEST_FULL = (1 << NEST_W) - 1;
  localparam logic [NEST_W-1:0] NEST_CAP =
    (MAX_NEST < NEST_FULL) ? NEST_W'(MAX_NEST) : NEST_W'(NEST_FULL);

  localparam logic [CP_W-1:0] CH_EOI   = 21'h00_0000;
  localparam logic [CP_W-1:0] CH_TAB   = 21'h00_0009;
  localparam logic [CP_W-1:0] CH_LF    = 21'h00_000A;
  localparam logic [CP_W-1:0] CH_CR    = 21'h00_000D;
  localparam logic [CP_W-1:0] CH_SPACE = 21'h00_0020;
  localparam logic [CP_W-1:0] CH_STAR  = 21'h00_002A;
  localparam logic [CP_W-1:0] CH_SLASH = 21'h00_002F;

  // Bit positions in the allowed-kinds register.
  localparam int KIND_BLOCK = 0;
  localparam int KIND_LINE  = 1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SKIP       = 3'd1,
    PH_SLASH1     = 3'd2,
    PH_BODY       = 3'd3,
    PH_BODY_STAR  = 3'd4,
    PH_BODY_SLASH = 3'd5,
    PH_LINE       = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    VD_NONE   = 2'd0,
    VD_BLOCK  = 2'd1,
    VD_LINE   = 2'd2,
    VD_REJECT = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            scan_start;
    logic            multi_allowed;
    logic            single_allowed;
  } item_t;

  typedef struct packed {
    verdict_t          verdict;
    logic              in_token;
    logic              skipped;
    logic [NEST_W-1:0] nest_level;
  } result_t;

endpackage

// ===== hdl/nested_comment_scanner.sv =====
// Top level of the nested comment scanner: input register, scan core, result register.
// Takes one character word per clock when neither side stalls and returns one result
// word per character, in order. A word accepted into the input register steps the scan
// core once the result register is free or draining, and the result register loads
// its result as the core steps. Sustained throughput is one word per cycle while
// neither side stalls. That rate comes from the scan core updating its phase and depth
// registers once per step, seeing each character exactly once. Both sides may stall
// freely. While a result waits to be taken, the input register takes at most one more
// word and then holds off until the result drains. Block comment depth saturates at the
// package constant MAX_NEST, or at 255 if that is smaller.
module nested_comment_scanner
  import ncs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CP_W-1:0]   code_point,
  input  logic              scan_start,
  input  logic              multi_allowed,
  input  logic              single_allowed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        verdict,
  output logic              in_token,
  output logic              skipped,
  output logic [NEST_W-1:0] nest_level
);

  logic    hold_valid;
  item_t   hold;
  logic    advance;
  result_t res_next;
  result_t res;

  // A held word moves into the core whenever the result register is free or draining.
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= '{code_point: code_point, scan_start: scan_start,
                multi_allowed: multi_allowed, single_allowed: single_allowed};
    end
  end

  ncs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (hold),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign verdict    = res.verdict;
  assign in_token   = res.in_token;
  assign skipped    = res.skipped;
  assign nest_level = res.nest_level;

`ifndef SYNTHESIS
  a_no_loss_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && hold_valid) |-> !in_ready)
    else $error("input accepted with both stages full");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after core step");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res)))
    else $error("waiting result changed before it was taken");
`endif

endmodule

// ===== hdl/ncs_core.sv =====
// Phase and depth state machine that classifies one character per step.
module ncs_core
  import ncs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  phase_t            phase, phase_next;
  logic [NEST_W-1:0] nesting, nesting_next;
  logic [1:0]        kinds, kinds_next;

  phase_t            ph;
  logic [NEST_W-1:0] nest_cur;
  logic [NEST_W-1:0] nest_upd;
  logic [CP_W-1:0]   c;
  logic              is_space;
  logic              is_star;
  logic              is_slash;
  logic              is_eoi;
  phase_t            body_phase;

  assign c        = item.code_point;
  assign is_star  = (c == CH_STAR);
  assign is_slash = (c == CH_SLASH);
  assign is_eoi   = (c == CH_EOI);
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  // A scan start restarts the scan ahead of the character it carries.
  assign kinds_next = item.scan_start ? {item.single_allowed, item.multi_allowed} : kinds;
  assign ph         = item.scan_start ? PH_SKIP : phase;
  assign nest_cur   = item.scan_start ? '0 : nesting;

  // Where ordinary block content sends the scan.
  always_comb begin
    if (is_eoi) begin
      body_phase = PH_IDLE;
    end else if (is_star) begin
      body_phase = PH_BODY_STAR;
    end else if (is_slash) begin
      body_phase = PH_BODY_SLASH;
    end else begin
      body_phase = PH_BODY;
    end
  end

  // Next state.
  always_comb begin
    phase_next = PH_IDLE;
    nest_upd   = nest_cur;
    case (ph)
      PH_SKIP: begin
        if (is_space) begin
          phase_next = PH_SKIP;
        end else if (is_slash && (kinds_next != 2'b00)) begin
          phase_next = PH_SLASH1;
        end
      end
      PH_SLASH1: begin
        if (is_star && kinds_next[KIND_BLOCK]) begin
          phase_next = PH_BODY;
          nest_upd   = NEST_W'(1);
        end else if (is_slash && kinds_next[KIND_LINE]) begin
          phase_next = PH_LINE;
        end
      end
      PH_BODY: begin
        phase_next = body_phase;
      end
      PH_BODY_STAR: begin
        if (is_slash) begin
          if (nest_cur != '0) begin
            nest_upd = nest_cur - NEST_W'(1);
          end
          phase_next = (nest_upd == '0) ? PH_IDLE : PH_BODY;
        end else begin
          phase_next = body_phase;
        end
      end
      PH_BODY_SLASH: begin
        if (is_star) begin
          if (nest_cur < NEST_CAP) begin
            nest_upd = nest_cur + NEST_W'(1);
          end
          phase_next = PH_BODY;
        end else begin
          phase_next = body_phase;
        end
      end
      PH_LINE: begin
        phase_next = (is_eoi || (c == CH_LF)) ? PH_IDLE : PH_LINE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    nesting_next = (phase_next == PH_IDLE) ? '0 : nest_upd;
  end

  // Result word.
  always_comb begin
    res            = '0;
    res.verdict    = VD_NONE;
    res.nest_level = nesting_next;
    case (ph)
      PH_SKIP: begin
        if (is_space) begin
          res.skipped = 1'b1;
        end else if (is_slash && (kinds_next != 2'b00)) begin
          res.in_token = 1'b1;
        end else begin
          res.verdict = VD_REJECT;
        end
      end
      PH_SLASH1: begin
        if ((is_star && kinds_next[KIND_BLOCK]) || (is_slash && kinds_next[KIND_LINE])) begin
          res.in_token = 1'b1;
        end else begin
          res.verdict = VD_REJECT;
        end
      end
      PH_BODY, PH_BODY_STAR, PH_BODY_SLASH: begin
        if (is_eoi) begin
          res.verdict = VD_REJECT;
        end else begin
          res.in_token = 1'b1;
          if ((ph == PH_BODY_STAR) && is_slash && (phase_next == PH_IDLE)) begin
            res.verdict = VD_BLOCK;
          end
        end
      end
      PH_LINE: begin
        if (is_eoi || (c == CH_LF)) begin
          res.verdict = VD_LINE;
        end else begin
          res.in_token = 1'b1;
        end
      end
      default: begin
        res.verdict = VD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      nesting <= '0;
      kinds   <= 2'b00;
    end else if (step) begin
      phase   <= phase_next;
      nesting <= nesting_next;
      kinds   <= kinds_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_depth_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (nesting == '0))
    else $error("depth is not zero while idle");

  a_depth_capped: assert property (@(posedge clk) disable iff (rst)
    nesting <= NEST_CAP)
    else $error("depth above its cap");

  a_body_has_depth: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_BODY) || (phase == PH_BODY_STAR) || (phase == PH_BODY_SLASH))
      |-> (nesting != '0))
    else $error("inside a block comment with zero depth");

  a_verdict_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (step && (res.verdict != VD_NONE)) |=> (phase == PH_IDLE))
    else $error("scan did not end after a verdict");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the nested comment scanner: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module tb;
  import ncs_pkg::*;

  localparam int IDLE_PCT   = 27;
  localparam int CALM_FROM  = 300;
  localparam int CALM_TO    = 700;
  localparam int LIMIT      = 100000;
  localparam int RAND_CHARS = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CP_W-1:0]   code_point;
  logic              scan_start;
  logic              multi_allowed;
  logic              single_allowed;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        verdict;
  logic              in_token;
  logic              skipped;
  logic [NEST_W-1:0] nest_level;

  item_t   on_bus = '0;
  item_t   chars_to_send[$];
  result_t scan_results_due[$];

  // Running copy of the scanner's state, advanced once per accepted word.
  phase_t            scan_phase = PH_IDLE;
  logic [NEST_W-1:0] scan_depth = '0;
  logic [1:0]        scan_kinds = '0;

  int unsigned cycle = 0;
  int mismatches = 0;
  int queued_chars = 0;
  int noise_chars = 0;
  int scans_started = 0;
  int blocks_seen = 0;
  int lines_seen = 0;
  int rejects_seen = 0;
  int deepest = 0;

  bit   opening = 1'b0;
  logic pick_ma = 1'b0;
  logic pick_sa = 1'b0;

  wire calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

  assign code_point     = on_bus.code_point;
  assign scan_start     = on_bus.scan_start;
  assign multi_allowed  = on_bus.multi_allowed;
  assign single_allowed = on_bus.single_allowed;

  nested_comment_scanner u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .code_point     (code_point),
    .scan_start     (scan_start),
    .multi_allowed  (multi_allowed),
    .single_allowed (single_allowed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .in_token       (in_token),
    .skipped        (skipped),
    .nest_level     (nest_level)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ordinary content of a block comment: may end it on end of input.
  function automatic void block_content(input logic [CP_W-1:0] cp, output verdict_t vd,
                                        output logic tok);
    vd  = VD_NONE;
    tok = 1'b0;
    if (cp == CH_EOI) begin
      vd = VD_REJECT;
      scan_phase = PH_IDLE;
      scan_depth = '0;
    end else begin
      tok = 1'b1;
      if (cp == CH_STAR)
        scan_phase = PH_BODY_STAR;
      else if (cp == CH_SLASH)
        scan_phase = PH_BODY_SLASH;
      else
        scan_phase = PH_BODY;
    end
  endfunction

  function automatic result_t scan_step(input item_t w);
    result_t  r;
    verdict_t vd;
    logic     tok;
    logic     skip;
    vd   = VD_NONE;
    tok  = 1'b0;
    skip = 1'b0;
    if (w.scan_start) begin
      scan_kinds[KIND_BLOCK] = w.multi_allowed;
      scan_kinds[KIND_LINE]  = w.single_allowed;
      scan_phase = PH_SKIP;
      scan_depth = '0;
    end
    case (scan_phase)
      PH_SKIP: begin
        if (w.code_point == CH_SPACE ||
            (w.code_point >= CH_TAB && w.code_point <= CH_CR)) begin
          skip = 1'b1;
        end else if (w.code_point == CH_SLASH && scan_kinds != 2'b00) begin
          tok = 1'b1;
          scan_phase = PH_SLASH1;
        end else begin
          vd = VD_REJECT;
          scan_phase = PH_IDLE;
        end
      end
      PH_SLASH1: begin
        if (w.code_point == CH_STAR && scan_kinds[KIND_BLOCK]) begin
          tok = 1'b1;
          scan_depth = NEST_W'(1);
          scan_phase = PH_BODY;
        end else if (w.code_point == CH_SLASH && scan_kinds[KIND_LINE]) begin
          tok = 1'b1;
          scan_phase = PH_LINE;
        end else begin
          vd = VD_REJECT;
          scan_phase = PH_IDLE;
        end
      end
      PH_BODY: block_content(w.code_point, vd, tok);
      PH_BODY_STAR: begin
        if (w.code_point == CH_SLASH) begin
          tok = 1'b1;
          if (scan_depth != 0)
            scan_depth = scan_depth - 1'b1;
          if (scan_depth == 0) begin
            vd = VD_BLOCK;
            scan_phase = PH_IDLE;
          end else begin
            scan_phase = PH_BODY;
          end
        end else begin
          block_content(w.code_point, vd, tok);
        end
      end
      PH_BODY_SLASH: begin
        if (w.code_point == CH_STAR) begin
          tok = 1'b1;
          if (scan_depth < NEST_CAP)
            scan_depth = scan_depth + 1'b1;
          scan_phase = PH_BODY;
        end else begin
          block_content(w.code_point, vd, tok);
        end
      end
      PH_LINE: begin
        if (w.code_point == CH_EOI || w.code_point == CH_LF) begin
          vd = VD_LINE;
          scan_phase = PH_IDLE;
        end else begin
          tok = 1'b1;
        end
      end
      default: begin
        scan_phase = PH_IDLE;
        scan_depth = '0;
      end
    endcase
    if (scan_phase == PH_IDLE)
      scan_depth = '0;
    r.verdict    = vd;
    r.in_token   = tok;
    r.skipped    = skip;
    r.nest_level = scan_depth;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Driver: presents the next pending word, predicting each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      scan_phase = PH_IDLE;
      scan_depth = '0;
      scan_kinds = '0;
    end else begin
      if (in_valid && in_ready)
        scan_results_due.push_back(scan_step(on_bus));
      if (!in_valid || in_ready) begin
        if (chars_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus   <= chars_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every taken result word against the oldest prediction.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (scan_results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got verdict %0d depth %0d",
                   $time, verdict, nest_level);
          mismatches++;
        end else begin
          want = scan_results_due.pop_front();
          check_field("verdict", 8'(want.verdict), 8'(verdict));
          check_field("in_token", 8'(want.in_token), 8'(in_token));
          check_field("skipped", 8'(want.skipped), 8'(skipped));
          check_field("nest_level", want.nest_level, nest_level);
          case (want.verdict)
            VD_BLOCK:  blocks_seen++;
            VD_LINE:   lines_seen++;
            VD_REJECT: rejects_seen++;
            default: ;
          endcase
          if (int'(nest_level) > deepest)
            deepest = int'(nest_level);
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle, scan_results_due.size());
      $display("nested_comment_scanner verification failed");
      $finish;
    end
  end

  task automatic begin_scan(input logic ma, input logic sa);
    opening = 1'b1;
    pick_ma = ma;
    pick_sa = sa;
    scans_started++;
  endtask

  // Only the first word of a scan carries the start mark; the kind bits are noise elsewhere.
  task automatic send(input logic [CP_W-1:0] cp);
    item_t w;
    w.code_point     = cp;
    w.scan_start     = opening;
    w.multi_allowed  = opening ? pick_ma : 1'($urandom_range(1));
    w.single_allowed = opening ? pick_sa : 1'($urandom_range(1));
    opening = 1'b0;
    chars_to_send.push_back(w);
    queued_chars++;
  endtask

  function automatic logic [CP_W-1:0] rand_plain();
    logic [CP_W-1:0] cp;
    do begin
      case ($urandom_range(3))
        0, 1: cp = CP_W'($urandom_range(32'h7E, 32'h21));
        2: cp = CP_W'($urandom_range(32'h10FFFF, 1));
        default: begin
          case ($urandom_range(5))
            0: cp = 21'h00_0008;
            1: cp = 21'h00_000E;
            2: cp = 21'h00_001F;
            3: cp = 21'h00_007F;
            4: cp = 21'h10_0000;
            default: cp = 21'h10_FFFF;
          endcase
        end
      endcase
    end while (cp == CH_STAR || cp == CH_SLASH || cp == CH_LF || cp == CH_EOI);
    return cp;
  endfunction

  function automatic logic [CP_W-1:0] rand_space();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CP_W'($urandom_range(32'h0C, 32'h0A));
    endcase
  endfunction

  task automatic add_block_comment();
    int depth;
    int steps;
    depth = 1;
    steps = $urandom_range(14);
    send(CH_SLASH);
    send(CH_STAR);
    while (depth > 0 && steps > 0) begin
      steps--;
      case ($urandom_range(9))
        0, 1, 2: send(rand_plain());
        3: send(rand_space());
        4: begin
          send(CH_STAR);
          send(rand_plain());
        end
        5: begin
          send(CH_SLASH);
          send(rand_plain());
        end
        6, 7: begin
          if (depth < 4) begin
            send(CH_SLASH);
            send(CH_STAR);
            depth++;
          end else begin
            send(rand_plain());
          end
        end
        default: begin
          send(CH_STAR);
          send(CH_SLASH);
          depth--;
        end
      endcase
    end
    case ($urandom_range(9))
      0: if (depth > 0) send(CH_EOI);
      1: ;  // left open: the next scan cuts it short
      default: begin
        repeat (depth) begin
          send(CH_STAR);
          send(CH_SLASH);
        end
      end
    endcase
  endtask

  task automatic add_line_comment();
    logic [CP_W-1:0] cp;
    send(CH_SLASH);
    send(CH_SLASH);
    repeat ($urandom_range(8)) begin
      case ($urandom_range(5))
        0: cp = CH_STAR;
        1: cp = CH_SLASH;
        2: cp = rand_space();
        default: cp = rand_plain();
      endcase
      send(cp == CH_LF ? CH_SPACE : cp);
    end
    send($urandom_range(9) < 7 ? CH_LF : CH_EOI);
  endtask

  task automatic add_random_scan();
    int form;
    int n;
    form = $urandom_range(99);
    if (form >= 85) begin
      // Stray words with no start mark; ignored unless a scan is still open.
      n = $urandom_range(3, 1);
      repeat (n) send($urandom_range(1) ? rand_plain() : CH_SLASH);
      noise_chars += n;
    end else begin
      if (form < 40)
        begin_scan($urandom_range(9) != 0, 1'($urandom_range(1)));
      else if (form < 70)
        begin_scan(1'($urandom_range(1)), $urandom_range(9) != 0);
      else
        begin_scan(1'($urandom_range(1)), 1'($urandom_range(1)));
      repeat ($urandom_range(2)) send(rand_space());
      if (form < 40) begin
        add_block_comment();
      end else if (form < 70) begin
        add_line_comment();
      end else begin
        case ($urandom_range(3))
          0: send(CH_EOI);
          1: send(rand_plain());
          default: begin
            send(CH_SLASH);
            case ($urandom_range(2))
              0: send(rand_plain());
              1: send(CH_SLASH);
              default: send(CH_STAR);
            endcase
          end
        endcase
      end
    end
  endtask

  task automatic wait_drained();
    while (chars_to_send.size() != 0 || in_valid || scan_results_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;

    // Directed words: ignored idle word, each verdict and each corner of the grammar.
    send(21'h10_FFFF);
    begin_scan(1'b1, 1'b1);
    send(CH_SPACE);
    send(CH_SLASH);
    send(CH_SLASH);
    send(21'h00_0061);
    send(CH_LF);
    begin_scan(1'b1, 1'b0);
    send(CH_SLASH);
    send(CH_STAR);
    send(CH_SLASH);
    send(CH_STAR);
    send(CH_STAR);
    send(21'h00_0078);
    send(CH_SLASH);
    send(21'h00_0078);
    send(CH_STAR);
    send(CH_SLASH);
    send(CH_STAR);
    send(CH_SLASH);
    begin_scan(1'b0, 1'b1);
    send(CH_SLASH);
    send(CH_STAR);
    begin_scan(1'b0, 1'b0);
    send(CH_SLASH);
    begin_scan(1'b1, 1'b1);
    send(CH_EOI);
    begin_scan(1'b1, 1'b0);
    send(CH_SLASH);
    send(CH_STAR);
    send(CH_EOI);
    begin_scan(1'b0, 1'b1);
    send(CH_TAB);
    send(CH_SLASH);
    send(CH_SLASH);
    send(CH_EOI);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // Opens past the depth limit, where the depth stays put, backs out twice and then
    // runs out of input inside the comment.
    begin_scan(1'b1, 1'b1);
    send(CH_SLASH);
    send(CH_STAR);
    repeat (int'(NEST_CAP) + 1) begin
      send(CH_SLASH);
      send(CH_STAR);
    end
    repeat (2) begin
      send(CH_STAR);
      send(CH_SLASH);
    end
    send(CH_EOI);

    queued_chars = 0;
    noise_chars  = 0;
    while (queued_chars - noise_chars < RAND_CHARS) begin
      add_random_scan();
      if (!paused && queued_chars > RAND_CHARS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Ran %0d scans: %0d block comments, %0d line comments and %0d rejections.",
             scans_started, blocks_seen, lines_seen, rejects_seen);
    $display("Deepest nesting reported was %0d; %0d mismatches.", deepest, mismatches);
    if (mismatches == 0)
      $display("nested_comment_scanner verification clean");
    else
      $display("nested_comment_scanner verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ncs_pkg.sv
hdl/ncs_core.sv
hdl/nested_comment_scanner.sv
bench/tb.sv
